@@ rtl/point_transform_unit_defines.svh @@
// ----------------------------------------------------------------------------
// point transform unit assertion macros
// shared assertion shorthands for the point transform unit
// ----------------------------------------------------------------------------
`ifndef POINT_TRANSFORM_UNIT_DEFINES_SVH
`define POINT_TRANSFORM_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define PTU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PTU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ptu_pkg.sv @@
// ----------------------------------------------------------------------------
// ptu_pkg
// types, constants and the arctangent table of the point transform unit
// ----------------------------------------------------------------------------
`default_nettype none

package ptu_pkg;

	localparam int COORD_WIDTH_DEF     = 24;
	localparam int FRAC_BITS_DEF       = 8;
	localparam int ROTATION_STAGES_DEF = 16;

	localparam int CMD_WIDTH   = 2;
	localparam int QUAD_WIDTH  = 2;
	localparam int RATIO_WIDTH = 16;
	localparam int RATIO_FRAC  = 8;
	localparam int ANGLE_WIDTH = 9;

	// cordic datapath: q2.30 vector, angle in 2^-20 degree units
	localparam int TRIG_WIDTH       = 32;
	localparam int TRIG_FRAC        = 30;
	localparam int ZW               = 30;
	localparam int ANGLE_UNIT_SHIFT = 20;

	localparam logic signed [TRIG_WIDTH-1:0] CORDIC_GAIN = 32'sd652032874;

	localparam logic [ANGLE_WIDTH-1:0] DEG_90  = 9'd90;
	localparam logic [ANGLE_WIDTH-1:0] DEG_180 = 9'd180;
	localparam logic [ANGLE_WIDTH-1:0] DEG_270 = 9'd270;
	localparam logic [ANGLE_WIDTH-1:0] DEG_360 = 9'd360;

	typedef enum logic [CMD_WIDTH-1:0] {
		CMD_TRANSLATE = 2'd0,
		CMD_SCALE     = 2'd1,
		CMD_ROTATE    = 2'd2,
		CMD_PASS      = 2'd3
	} cmd_t;

	typedef enum logic [QUAD_WIDTH-1:0] {
		QUAD_I   = 2'd0,
		QUAD_II  = 2'd1,
		QUAD_III = 2'd2,
		QUAD_IV  = 2'd3
	} quad_t;

	// side word carried alongside the cordic vector, lowest bits first:
	// cmd, quad, ratio, px, py, rx, ry, dx, dy
	localparam int SIDE_CMD   = 0;
	localparam int SIDE_QUAD  = SIDE_CMD + CMD_WIDTH;
	localparam int SIDE_RATIO = SIDE_QUAD + QUAD_WIDTH;
	localparam int SIDE_COORD = SIDE_RATIO + RATIO_WIDTH;

	function automatic int side_width(input int cw);
		return SIDE_COORD + 6 * cw + 2;
	endfunction

	// atan(2^-i) in 2^-20 degree units
	function automatic logic signed [ZW-1:0] atan_step(input int idx);
		case (idx)
			0:       return 30'sd47185920;
			1:       return 30'sd27855475;
			2:       return 30'sd14718068;
			3:       return 30'sd7471121;
			4:       return 30'sd3750058;
			5:       return 30'sd1876857;
			6:       return 30'sd938658;
			7:       return 30'sd469357;
			8:       return 30'sd234682;
			9:       return 30'sd117342;
			10:      return 30'sd58671;
			11:      return 30'sd29335;
			12:      return 30'sd14668;
			13:      return 30'sd7334;
			14:      return 30'sd3667;
			15:      return 30'sd1833;
			16:      return 30'sd917;
			17:      return 30'sd458;
			18:      return 30'sd229;
			19:      return 30'sd115;
			20:      return 30'sd57;
			21:      return 30'sd29;
			22:      return 30'sd14;
			23:      return 30'sd7;
			default: return '0;
		endcase
	endfunction

endpackage

`default_nettype wire

@@ rtl/ptu_prep.sv @@
// ----------------------------------------------------------------------------
// ptu_prep
// input stage: offsets from the centre, angle folded into quadrant and rest
// ----------------------------------------------------------------------------
`default_nettype none

module ptu_prep import ptu_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int SIDE_W      = side_width(COORD_WIDTH_DEF)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire cmd_t                          in_cmd,
	input  wire logic signed [COORD_WIDTH-1:0] in_px,
	input  wire logic signed [COORD_WIDTH-1:0] in_py,
	input  wire logic signed [COORD_WIDTH-1:0] in_rx,
	input  wire logic signed [COORD_WIDTH-1:0] in_ry,
	input  wire logic signed [RATIO_WIDTH-1:0] in_ratio,
	input  wire logic [ANGLE_WIDTH-1:0]        in_angle,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [ZW-1:0]               out_z,
	output logic [SIDE_W-1:0]                  out_side
);

	localparam int DW = COORD_WIDTH + 1;

	logic                   valid_s1;
	logic signed [ZW-1:0]   z_s1;
	logic [SIDE_W-1:0]      side_s1;

	logic [ANGLE_WIDTH-1:0] ang_w;
	logic [ANGLE_WIDTH-1:0] rem_w;
	quad_t                  quad_w;
	logic signed [DW-1:0]   dx_w;
	logic signed [DW-1:0]   dy_w;
	logic signed [ZW-1:0]   z_w;

	always_comb begin
		ang_w = (in_angle >= DEG_360) ? (in_angle - DEG_360) : in_angle;
		if (ang_w >= DEG_270) begin
			quad_w = QUAD_IV;
			rem_w  = ang_w - DEG_270;
		end else if (ang_w >= DEG_180) begin
			quad_w = QUAD_III;
			rem_w  = ang_w - DEG_180;
		end else if (ang_w >= DEG_90) begin
			quad_w = QUAD_II;
			rem_w  = ang_w - DEG_90;
		end else begin
			quad_w = QUAD_I;
			rem_w  = ang_w;
		end
		z_w  = {{(ZW-ANGLE_WIDTH-ANGLE_UNIT_SHIFT){1'b0}}, rem_w, {ANGLE_UNIT_SHIFT{1'b0}}};
		dx_w = DW'(in_px) - DW'(in_rx);
		dy_w = DW'(in_py) - DW'(in_ry);
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			z_s1    <= z_w;
			side_s1 <= {dy_w, dx_w, in_ry, in_rx, in_py, in_px, in_ratio, quad_w, in_cmd};
		end
	end

	assign out_valid = valid_s1;
	assign out_z     = z_s1;
	assign out_side  = side_s1;

endmodule

`default_nettype wire

@@ rtl/ptu_cordic_stage.sv @@
// ----------------------------------------------------------------------------
// ptu_cordic_stage
// one registered micro-rotation of the sine and cosine generator
// ----------------------------------------------------------------------------
`default_nettype none

module ptu_cordic_stage import ptu_pkg::*; #(
	parameter int STAGE  = 0,
	parameter int SIDE_W = side_width(COORD_WIDTH_DEF)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [TRIG_WIDTH-1:0] in_x,
	input  wire logic signed [TRIG_WIDTH-1:0] in_y,
	input  wire logic signed [ZW-1:0]         in_z,
	input  wire logic [SIDE_W-1:0]            in_side,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [TRIG_WIDTH-1:0]      out_x,
	output logic signed [TRIG_WIDTH-1:0]      out_y,
	output logic signed [ZW-1:0]              out_z,
	output logic [SIDE_W-1:0]                 out_side
);

	localparam logic signed [ZW-1:0] ATAN = atan_step(STAGE);

	logic                         valid_s;
	logic signed [TRIG_WIDTH-1:0] x_s;
	logic signed [TRIG_WIDTH-1:0] y_s;
	logic signed [ZW-1:0]         z_s;
	logic [SIDE_W-1:0]            side_s;

	logic signed [TRIG_WIDTH-1:0] x_n;
	logic signed [TRIG_WIDTH-1:0] y_n;
	logic signed [ZW-1:0]         z_n;

	// rotate towards the residual angle, sign of z picks the direction
	always_comb begin
		if (!in_z[ZW-1]) begin
			x_n = in_x - (in_y >>> STAGE);
			y_n = in_y + (in_x >>> STAGE);
			z_n = in_z - ATAN;
		end else begin
			x_n = in_x + (in_y >>> STAGE);
			y_n = in_y - (in_x >>> STAGE);
			z_n = in_z + ATAN;
		end
	end

	assign in_ready = !valid_s || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (in_ready) begin
			valid_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			x_s    <= x_n;
			y_s    <= y_n;
			z_s    <= z_n;
			side_s <= in_side;
		end
	end

	assign out_valid = valid_s;
	assign out_x     = x_s;
	assign out_y     = y_s;
	assign out_z     = z_s;
	assign out_side  = side_s;

endmodule

`default_nettype wire

@@ rtl/ptu_tail.sv @@
// ----------------------------------------------------------------------------
// ptu_tail
// quadrant fix-up, products, truncation, centre add and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module ptu_tail import ptu_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int SIDE_W      = side_width(COORD_WIDTH_DEF)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [TRIG_WIDTH-1:0] in_x,
	input  wire logic signed [TRIG_WIDTH-1:0] in_y,
	input  wire logic [SIDE_W-1:0]            in_side,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [COORD_WIDTH-1:0]            out_x,
	output logic [COORD_WIDTH-1:0]            out_y,
	output logic                              out_ovf
);

	localparam int W    = COORD_WIDTH;
	localparam int DW   = W + 1;
	localparam int PW   = TRIG_WIDTH + DW;
	localparam int VW   = PW + 1;
	localparam int OW   = W + 10;
	localparam int SUMW = OW + 1;
	localparam int RS   = TRIG_FRAC + FRAC_BITS;

	localparam int O_PX = SIDE_COORD;
	localparam int O_PY = O_PX + W;
	localparam int O_RX = O_PY + W;
	localparam int O_RY = O_RX + W;
	localparam int O_DX = O_RY + W;
	localparam int O_DY = O_DX + DW;

	localparam logic signed [VW-1:0] BIAS_ROT   = {{(VW-RS){1'b0}}, {RS{1'b1}}};
	localparam logic signed [VW-1:0] BIAS_SCALE = {{(VW-RATIO_FRAC){1'b0}}, {RATIO_FRAC{1'b1}}};
	localparam logic signed [SUMW-1:0] SAT_HI   = {{(SUMW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [SUMW-1:0] SAT_LO   = {{(SUMW-W+1){1'b1}}, {(W-1){1'b0}}};

	// stage numbers here are local to the tail
	logic                         valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic                         rdy1, rdy2, rdy3, rdy4, rdy5;

	cmd_t                         cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic signed [TRIG_WIDTH-1:0] mc_s1, ms_s1;
	logic signed [DW-1:0]         dx_s1, dy_s1;
	logic signed [W-1:0]          px_s1, py_s1, rx_s1, ry_s1;
	logic signed [W-1:0]          px_s2, py_s2, rx_s2, ry_s2;
	logic signed [W-1:0]          px_s3, py_s3, rx_s3, ry_s3;
	logic signed [PW-1:0]         pcx_s2, psy_s2, psx_s2, pcy_s2;
	logic signed [VW-1:0]         vx_s3, vy_s3;
	logic signed [OW-1:0]         offx_s4, offy_s4, basex_s4, basey_s4;
	logic [W-1:0]                 resx_s5, resy_s5;
	logic                         ovf_s5;

	cmd_t                         cmd_w;
	quad_t                        quad_w;
	logic signed [RATIO_WIDTH-1:0] ratio_w;
	logic signed [TRIG_WIDTH-1:0] cos_w, sin_w;

	logic signed [VW-1:0]         brx_w, bry_w, bsx_w, bsy_w;
	logic signed [VW-1:0]         trx_w, try_w, tsx_w, tsy_w;
	logic signed [VW-1:0]         wrx_w, wry_w;
	logic signed [OW-1:0]         offx_w, offy_w, basex_w, basey_w;

	logic signed [SUMW-1:0]       sumx_w, sumy_w;
	logic [W-1:0]                 resx_w, resy_w;
	logic                         ovfx_w, ovfy_w;

	assign rdy5     = !valid_s5 || out_ready;
	assign rdy4     = !valid_s4 || rdy5;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
		end
	end

	// quadrant by exact swaps and negations; scale borrows the multipliers
	always_comb begin
		cmd_w   = cmd_t'(in_side[SIDE_CMD +: CMD_WIDTH]);
		quad_w  = quad_t'(in_side[SIDE_QUAD +: QUAD_WIDTH]);
		ratio_w = in_side[SIDE_RATIO +: RATIO_WIDTH];
		case (quad_w)
			QUAD_I: begin
				cos_w = in_x;
				sin_w = in_y;
			end
			QUAD_II: begin
				cos_w = -in_y;
				sin_w = in_x;
			end
			QUAD_III: begin
				cos_w = -in_x;
				sin_w = -in_y;
			end
			default: begin
				cos_w = in_y;
				sin_w = -in_x;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			cmd_s1 <= cmd_w;
			mc_s1  <= (cmd_w == CMD_SCALE) ? TRIG_WIDTH'(ratio_w) : cos_w;
			ms_s1  <= (cmd_w == CMD_SCALE) ? '0 : sin_w;
			dx_s1  <= in_side[O_DX +: DW];
			dy_s1  <= in_side[O_DY +: DW];
			px_s1  <= in_side[O_PX +: W];
			py_s1  <= in_side[O_PY +: W];
			rx_s1  <= in_side[O_RX +: W];
			ry_s1  <= in_side[O_RY +: W];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			cmd_s2 <= cmd_s1;
			pcx_s2 <= mc_s1 * dx_s1;
			psy_s2 <= ms_s1 * dy_s1;
			psx_s2 <= ms_s1 * dx_s1;
			pcy_s2 <= mc_s1 * dy_s1;
			px_s2  <= px_s1;
			py_s2  <= py_s1;
			rx_s2  <= rx_s1;
			ry_s2  <= ry_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			cmd_s3 <= cmd_s2;
			vx_s3  <= VW'(pcx_s2) - VW'(psy_s2);
			vy_s3  <= VW'(psx_s2) + VW'(pcy_s2);
			px_s3  <= px_s2;
			py_s3  <= py_s2;
			rx_s3  <= rx_s2;
			ry_s3  <= ry_s2;
		end
	end

	// truncation toward zero: bias negative values before the shift
	always_comb begin
		brx_w = vx_s3[VW-1] ? BIAS_ROT : '0;
		bry_w = vy_s3[VW-1] ? BIAS_ROT : '0;
		bsx_w = vx_s3[VW-1] ? BIAS_SCALE : '0;
		bsy_w = vy_s3[VW-1] ? BIAS_SCALE : '0;
		trx_w = (vx_s3 + brx_w) >>> RS;
		try_w = (vy_s3 + bry_w) >>> RS;
		tsx_w = (vx_s3 + bsx_w) >>> RATIO_FRAC;
		tsy_w = (vy_s3 + bsy_w) >>> RATIO_FRAC;
		wrx_w = trx_w <<< FRAC_BITS;
		wry_w = try_w <<< FRAC_BITS;
		case (cmd_s3)
			CMD_ROTATE: begin
				offx_w = wrx_w[OW-1:0];
				offy_w = wry_w[OW-1:0];
			end
			CMD_SCALE: begin
				offx_w = tsx_w[OW-1:0];
				offy_w = tsy_w[OW-1:0];
			end
			default: begin
				offx_w = OW'(px_s3);
				offy_w = OW'(py_s3);
			end
		endcase
		basex_w = (cmd_s3 == CMD_PASS) ? '0 : OW'(rx_s3);
		basey_w = (cmd_s3 == CMD_PASS) ? '0 : OW'(ry_s3);
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			cmd_s4   <= cmd_s3;
			offx_s4  <= offx_w;
			offy_s4  <= offy_w;
			basex_s4 <= basex_w;
			basey_s4 <= basey_w;
		end
	end

	always_comb begin
		sumx_w = SUMW'(offx_s4) + SUMW'(basex_s4);
		sumy_w = SUMW'(offy_s4) + SUMW'(basey_s4);
		ovfx_w = (sumx_w > SAT_HI) || (sumx_w < SAT_LO);
		ovfy_w = (sumy_w > SAT_HI) || (sumy_w < SAT_LO);
		if (sumx_w > SAT_HI) begin
			resx_w = SAT_HI[W-1:0];
		end else if (sumx_w < SAT_LO) begin
			resx_w = SAT_LO[W-1:0];
		end else begin
			resx_w = sumx_w[W-1:0];
		end
		if (sumy_w > SAT_HI) begin
			resy_w = SAT_HI[W-1:0];
		end else if (sumy_w < SAT_LO) begin
			resy_w = SAT_LO[W-1:0];
		end else begin
			resy_w = sumy_w[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			resx_s5 <= resx_w;
			resy_s5 <= resy_w;
			// the pass command never saturates, the flag is kept explicit
			ovf_s5  <= (cmd_s4 != CMD_PASS) && (ovfx_w || ovfy_w);
		end
	end

	assign out_valid = valid_s5;
	assign out_x     = resx_s5;
	assign out_y     = resy_s5;
	assign out_ovf   = ovf_s5;

endmodule

`default_nettype wire

@@ rtl/point_transform_unit.sv @@
// path: an accepted word passes the prep stage, the cordic stages and the tail stages
// throughput: one word per cycle unless the output stalls; the cordic runs one micro-rotation per pipeline stage
// stalls: every full stage holds when the one after it cannot take, empty stages fill up meanwhile
// reset: arst_n clears the valid bit of every stage, payload registers are not reset
// ----------------------------------------------------------------------------
// point_transform_unit
// translates, scales, rotates or passes one q16.8 point per word, saturating results
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_transform_unit_defines.svh"

module point_transform_unit import ptu_pkg::*; #(
	parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
	parameter int FRAC_BITS       = FRAC_BITS_DEF,
	parameter int ROTATION_STAGES = ROTATION_STAGES_DEF,
	localparam int IN_DW  = ((4 * COORD_WIDTH + RATIO_WIDTH + ANGLE_WIDTH + 7) / 8) * 8,
	localparam int OUT_DW = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	// point_x, point_y, ref_x, ref_y, ratio, angle_deg, zero pad
	input  wire logic [IN_DW-1:0]  s_axis_tdata,
	// command
	input  wire logic [CMD_WIDTH-1:0] s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// result_x, result_y, zero pad
	output logic [OUT_DW-1:0]      m_axis_tdata,
	// overflow
	output logic                   m_axis_tuser
);

	localparam int W      = COORD_WIDTH;
	localparam int R      = ROTATION_STAGES;
	localparam int SIDE_W = side_width(COORD_WIDTH);
	localparam int O_RAT  = 4 * W;
	localparam int O_ANG  = O_RAT + RATIO_WIDTH;

	localparam logic [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};

	logic                         c_valid [0:R];
	logic                         c_ready [0:R];
	logic signed [TRIG_WIDTH-1:0] c_x     [0:R];
	logic signed [TRIG_WIDTH-1:0] c_y     [0:R];
	logic signed [ZW-1:0]         c_z     [0:R];
	logic [SIDE_W-1:0]            c_side  [0:R];

	logic [W-1:0]                 result_x;
	logic [W-1:0]                 result_y;

	ptu_prep #(
		.COORD_WIDTH (COORD_WIDTH),
		.SIDE_W      (SIDE_W)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (cmd_t'(s_axis_tuser)),
		.in_px     (s_axis_tdata[0 +: W]),
		.in_py     (s_axis_tdata[W +: W]),
		.in_rx     (s_axis_tdata[2*W +: W]),
		.in_ry     (s_axis_tdata[3*W +: W]),
		.in_ratio  (s_axis_tdata[O_RAT +: RATIO_WIDTH]),
		.in_angle  (s_axis_tdata[O_ANG +: ANGLE_WIDTH]),
		.out_valid (c_valid[0]),
		.out_ready (c_ready[0]),
		.out_z     (c_z[0]),
		.out_side  (c_side[0])
	);

	// rotation starts from (K, 0) so the result needs no gain correction
	assign c_x[0] = CORDIC_GAIN;
	assign c_y[0] = '0;

	for (genvar i = 0; i < R; i++) begin : g_cordic
		ptu_cordic_stage #(
			.STAGE  (i),
			.SIDE_W (SIDE_W)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_valid[i]),
			.in_ready  (c_ready[i]),
			.in_x      (c_x[i]),
			.in_y      (c_y[i]),
			.in_z      (c_z[i]),
			.in_side   (c_side[i]),
			.out_valid (c_valid[i+1]),
			.out_ready (c_ready[i+1]),
			.out_x     (c_x[i+1]),
			.out_y     (c_y[i+1]),
			.out_z     (c_z[i+1]),
			.out_side  (c_side[i+1])
		);
	end

	ptu_tail #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS),
		.SIDE_W      (SIDE_W)
	) u_tail (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (c_valid[R]),
		.in_ready  (c_ready[R]),
		.in_x      (c_x[R]),
		.in_y      (c_y[R]),
		.in_side   (c_side[R]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_x     (result_x),
		.out_y     (result_y),
		.out_ovf   (m_axis_tuser)
	);

	assign m_axis_tdata = {{(OUT_DW-2*W){1'b0}}, result_y, result_x};

	`PTU_ASSERT_SAME(a_ovf_at_limit, clk, arst_n, m_axis_tvalid && m_axis_tuser,
		result_x == COORD_MAX || result_x == COORD_MIN ||
		result_y == COORD_MAX || result_y == COORD_MIN,
		"overflow flagged on an unsaturated word")
	`PTU_ASSERT_SAME(a_ready_when_drained, clk, arst_n, !m_axis_tvalid, s_axis_tready,
		"input stalled although the output stage is empty")
	`PTU_ASSERT_SAME(a_ready_follows_sink, clk, arst_n, m_axis_tready, s_axis_tready,
		"input stalled although the sink takes words")
	`PTU_ASSERT_NEXT(a_accept_lands, clk, arst_n, s_axis_tvalid && s_axis_tready, c_valid[0],
		"accepted word missing from the first stage")

endmodule

`default_nettype wire
